FILE: rtl/rpuf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the range-parallel union-find engine
package rpuf_pkg;

  localparam int IDX_W   = 6;
  localparam int LVL_W   = 3;
  localparam int LEN_W   = 7;
  localparam int ENT_W   = 8;
  localparam int TADDR_W = LVL_W + IDX_W;
  localparam int STK_DEPTH = 16;
  localparam int SP_W    = 5;

  localparam logic [ENT_W-1:0] ENTRY_SINGLE = 8'hFF;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [ENT_W-1:0] ent_t;

  typedef enum logic [1:0] {
    CMD_MERGE = 2'd0,
    CMD_SAME  = 2'd1,
    CMD_ROOT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // pending block of pairs: starts and level
  typedef struct packed {
    idx_t x;
    idx_t y;
    lvl_t k;
  } blk_t;

  // result fields other than last
  typedef struct packed {
    idx_t new_root;
    idx_t absorbed_root;
    logic pair_valid;
    logic same_set;
    idx_t root_index;
    logic range_error;
  } res_t;

  // table write request
  typedef struct packed {
    logic                en;
    logic [TADDR_W-1:0]  addr;
    ent_t                data;
  } tbl_wr_t;

endpackage

FILE: rtl/rpuf_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for commands and results
interface rpuf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] first_index;
  logic [5:0] second_index;
  logic [6:0] run_length;
  modport source (output valid, cmd, first_index, second_index, run_length, input ready);
  modport sink   (input valid, cmd, first_index, second_index, run_length, output ready);
endinterface

interface rpuf_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] new_root;
  logic [5:0] absorbed_root;
  logic       pair_valid;
  logic       same_set;
  logic [5:0] root_index;
  logic       range_error;
  logic       last;
  modport source (output valid, new_root, absorbed_root, pair_valid, same_set, root_index,
                  range_error, last, input ready);
  modport sink   (input valid, new_root, absorbed_root, pair_valid, same_set, root_index,
                  range_error, last, output ready);
endinterface

FILE: rtl/rpuf_table.sv
`timescale 1ns / 1ps
// parent-or-size tables of all levels in one synchronous ram
module rpuf_table
  import rpuf_pkg::*;
#(
  parameter int DEPTH = 448,
  parameter int AW    = 9
) (
  input  logic               clk,
  input  tbl_wr_t            wr,
  input  logic [TADDR_W-1:0] rd_addr,
  output ent_t               rd_data
);

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rd_data <= mem[rd_addr[AW-1:0]];
  end

endmodule

FILE: rtl/range_parallel_union_find_top.sv
`timescale 1ns / 1ps
// range-parallel union-find engine: top level with command sequencer
// throughput: one command at a time; a query walks the chain of each root in the table,
//   a merge walks both chains of every block that it checks in the table
// latency: a union result is held until the next union or the end of the merge
// reset: synchronous; afterwards a clearing pass writes every table entry to singleton,
//   and no command is accepted until it ends
module range_parallel_union_find_top
  import rpuf_pkg::*;
#(
  parameter int ELEMENTS = 64,
  parameter int LEVELS   = 7
) (
  input  logic      clk,
  input  logic      rst,
  rpuf_req_if.sink  req,
  rpuf_rsp_if.source rsp
);

  localparam int TBL_DEPTH = LEVELS * 64;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_POP     = 12'b0000_0000_0100,
    S_FA_REQ  = 12'b0000_0000_1000,
    S_FA_WAIT = 12'b0000_0001_0000,
    S_FB_REQ  = 12'b0000_0010_0000,
    S_FB_WAIT = 12'b0000_0100_0000,
    S_UNITE   = 12'b0000_1000_0000,
    S_LINK    = 12'b0001_0000_0000,
    S_SPLIT   = 12'b0010_0000_0000,
    S_EMIT    = 12'b0100_0000_0000,
    S_FINAL   = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // command registers
  cmd_t cmd;
  // walk registers: level, chain cursors, roots and their size entries
  lvl_t lvl;
  idx_t cur_a, cur_b, ra, rb, keep, gone, bx, by;
  ent_t va, vb;
  // clearing pass counter
  logic [TBL_AW-1:0] clr_cnt;
  // split stack
  blk_t             stk [STK_DEPTH];
  logic [SP_W-1:0]  sp;
  // held result: sent when the next one arrives or at the end, so last can be marked
  res_t res;
  logic have;

  tbl_wr_t            wr;
  logic [TADDR_W-1:0] rd_addr;
  ent_t               rd_data;

  rpuf_table #(.DEPTH(TBL_DEPTH), .AW(TBL_AW)) u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // request decode
  logic [7:0] end_x, end_y;
  logic       merge_err, idx_err_x, idx_err_y, req_err;
  logic [LEN_W-1:0] len_m1, off;
  lvl_t       k0;
  idx_t       ox, oy;

  assign end_x     = {2'b00, req.first_index} + {1'b0, req.run_length};
  assign end_y     = {2'b00, req.second_index} + {1'b0, req.run_length};
  assign merge_err = (end_x > 8'(ELEMENTS)) || (end_y > 8'(ELEMENTS));
  assign idx_err_x = {1'b0, req.first_index} >= 7'(ELEMENTS);
  assign idx_err_y = {1'b0, req.second_index} >= 7'(ELEMENTS);
  assign len_m1    = req.run_length - 7'd1;

  // range flag of the incoming command
  always_comb begin
    unique case (cmd_t'(req.cmd))
      CMD_MERGE: req_err = merge_err;
      CMD_SAME:  req_err = idx_err_x || idx_err_y;
      CMD_ROOT:  req_err = idx_err_x;
      CMD_NONE:  req_err = 1'b0;
      default:   req_err = 1'b0;
    endcase
  end

  // block level: floor log2 of run_length-1, zero for a single pair
  always_comb begin
    k0 = '0;
    for (int i = 1; i < LEN_W; i++) begin
      if (len_m1[i]) k0 = lvl_t'(i);
    end
  end

  assign off = req.run_length - (7'd1 << k0);
  assign ox  = req.first_index + off[IDX_W-1:0];
  assign oy  = req.second_index + off[IDX_W-1:0];

  // top of stack, and the level that needs no table check
  blk_t top_blk;
  logic top_beyond;
  assign top_blk    = stk[sp[3:0] - 4'd1];
  assign top_beyond = {1'b0, top_blk.k} >= 4'(LEVELS);

  // union decision
  logic swap;
  assign swap = $signed(va) < $signed(vb);

  idx_t half;
  assign half = idx_t'(1) << (lvl - lvl_t'(1));

  logic slot_free;
  assign slot_free = !rsp.valid || rsp.ready;

  // a new result transfer is loaded this cycle
  logic send_now;
  assign send_now = ((state == S_EMIT) && have && slot_free) ||
                    ((state == S_FINAL) && slot_free);

  assign req.ready = (state == S_IDLE);

  // table read: chain cursor of whichever root is being walked
  always_comb begin
    rd_addr = {lvl, cur_a};
    if (state == S_FB_REQ) rd_addr = {lvl, cur_b};
  end

  // table write: clearing pass, size update, link of absorbed root
  always_comb begin
    wr = '0;
    unique case (state)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = TADDR_W'(clr_cnt);
        wr.data = ENTRY_SINGLE;
      end
      S_UNITE: begin
        wr.en   = (ra != rb);
        wr.addr = {lvl, swap ? rb : ra};
        wr.data = va + vb;
      end
      S_LINK: begin
        wr.en   = 1'b1;
        wr.addr = {lvl, gone};
        wr.data = {2'b00, keep};
      end
      default: wr = '0;
    endcase
  end

  // split stack pushes
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid && cmd_t'(req.cmd) == CMD_MERGE) begin
      stk[0] <= '{x: ox, y: oy, k: k0};
      stk[1] <= '{x: req.first_index, y: req.second_index, k: k0};
    end else if (state == S_SPLIT) begin
      stk[sp[3:0]]         <= '{x: bx + half, y: by + half, k: lvl - lvl_t'(1)};
      stk[sp[3:0] + 4'd1]  <= '{x: bx, y: by, k: lvl - lvl_t'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      sp        <= '0;
      have      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !send_now) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == TBL_AW'(TBL_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd   <= cmd_t'(req.cmd);
            res   <= '{new_root: '0, absorbed_root: '0, pair_valid: 1'b0,
                       same_set: 1'b0, root_index: '0, range_error: req_err};
            have  <= 1'b0;
            lvl   <= '0;
            cur_a <= req.first_index;
            // a root query walks the same element twice
            cur_b <= (cmd_t'(req.cmd) == CMD_ROOT) ? req.first_index : req.second_index;
            unique case (cmd_t'(req.cmd))
              CMD_MERGE: begin
                if (merge_err) begin
                  state <= S_FINAL;
                end else if (req.run_length == '0) begin
                  state <= S_FINAL;
                end else begin
                  sp    <= SP_W'(2);
                  state <= S_POP;
                end
              end
              CMD_SAME: begin
                if (idx_err_x || idx_err_y) begin
                  state <= S_FINAL;
                end else begin
                  state <= S_FA_REQ;
                end
              end
              CMD_ROOT: begin
                if (idx_err_x) begin
                  state <= S_FINAL;
                end else begin
                  state <= S_FA_REQ;
                end
              end
              CMD_NONE: state <= S_FINAL;
              default:  state <= S_FINAL;
            endcase
          end
        end
        S_POP: begin
          if (sp == '0) begin
            state <= S_FINAL;
          end else begin
            sp    <= sp - 1'b1;
            lvl   <= top_blk.k;
            cur_a <= top_blk.x;
            cur_b <= top_blk.y;
            bx    <= top_blk.x;
            by    <= top_blk.y;
            state <= top_beyond ? S_SPLIT : S_FA_REQ;
          end
        end
        S_FA_REQ: state <= S_FA_WAIT;
        S_FA_WAIT: begin
          if (rd_data[ENT_W-1]) begin
            ra    <= cur_a;
            va    <= rd_data;
            state <= S_FB_REQ;
          end else begin
            cur_a <= rd_data[IDX_W-1:0];
            state <= S_FA_REQ;
          end
        end
        S_FB_REQ: state <= S_FB_WAIT;
        S_FB_WAIT: begin
          if (rd_data[ENT_W-1]) begin
            rb <= cur_b;
            vb <= rd_data;
            priority case (cmd)
              CMD_SAME: begin
                res.same_set <= (ra == cur_b);
                state <= S_FINAL;
              end
              CMD_ROOT: begin
                res.root_index <= ra;
                state <= S_FINAL;
              end
              default: state <= S_UNITE;
            endcase
          end else begin
            cur_b <= rd_data[IDX_W-1:0];
            state <= S_FB_REQ;
          end
        end
        S_UNITE: begin
          if (ra == rb) begin
            state <= S_POP;
          end else begin
            // smaller set's root survives; tie keeps the first element's root
            keep  <= swap ? rb : ra;
            gone  <= swap ? ra : rb;
            state <= S_LINK;
          end
        end
        S_LINK: state <= (lvl == '0) ? S_EMIT : S_SPLIT;
        S_SPLIT: begin
          sp    <= sp + SP_W'(2);
          state <= S_POP;
        end
        S_EMIT: begin
          if (!have || slot_free) begin
            if (have) begin
              rsp.valid         <= 1'b1;
              rsp.new_root      <= res.new_root;
              rsp.absorbed_root <= res.absorbed_root;
              rsp.pair_valid    <= res.pair_valid;
              rsp.same_set      <= res.same_set;
              rsp.root_index    <= res.root_index;
              rsp.range_error   <= res.range_error;
              rsp.last          <= 1'b0;
            end
            res   <= '{new_root: keep, absorbed_root: gone, pair_valid: 1'b1,
                       same_set: 1'b0, root_index: '0, range_error: 1'b0};
            have  <= 1'b1;
            state <= S_POP;
          end
        end
        S_FINAL: begin
          if (slot_free) begin
            rsp.valid         <= 1'b1;
            rsp.new_root      <= res.new_root;
            rsp.absorbed_root <= res.absorbed_root;
            rsp.pair_valid    <= res.pair_valid;
            rsp.same_set      <= res.same_set;
            rsp.root_index    <= res.root_index;
            rsp.range_error   <= res.range_error;
            rsp.last          <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/rpuf_check.sv
`timescale 1ns / 1ps
// port-level checker for the union-find engine and its bind
module rpuf_check (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [5:0] new_root,
  input logic [5:0] absorbed_root,
  input logic       pair_valid,
  input logic       range_error,
  input logic       last
);

  // commands accepted whose final result has not been transferred
  logic [1:0] open_cnt;
  logic       acc, done;

  assign acc  = req_valid && req_ready;
  assign done = rsp_valid && rsp_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt <= '0;
    end else begin
      open_cnt <= open_cnt + {1'b0, acc} - {1'b0, done};
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    acc |-> (open_cnt == 2'd0) || ((open_cnt == 2'd1) && rsp_valid && last))
    else $error("command taken before previous one finished");

  a_rsp_owned: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready) |-> (open_cnt != 2'd0))
    else $error("result transfer with no command in flight");

  a_pair_sane: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && pair_valid) |-> (new_root != absorbed_root) && !range_error)
    else $error("union result with equal roots or error flag");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(new_root) && $stable(last))
    else $error("stalled result changed");

endmodule

bind range_parallel_union_find_top rpuf_check u_rpuf_check (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .new_root      (rsp.new_root),
  .absorbed_root (rsp.absorbed_root),
  .pair_valid    (rsp.pair_valid),
  .range_error   (rsp.range_error),
  .last          (rsp.last)
);

FILE: tb/rpuf_checker.sv
`timescale 1ns / 1ps
// result checker: predicts the union-find engine from accepted commands and compares results
module rpuf_checker
  import rpuf_pkg::*;
#(
  parameter int ELEMENTS = 64,
  parameter int LEVELS   = 7
) (
  input  logic clk,
  input  logic rst,
  rpuf_req_if  req,
  rpuf_rsp_if  rsp,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    res_t f;
    logic last;
  } outcome_t;

  logic signed [ENT_W-1:0] forest [LEVELS][ELEMENTS];
  blk_t     split_q [$];
  outcome_t outcome_q [$];

  function automatic idx_t find_root(int lvl, idx_t v);
    idx_t r, cur, nxt;
    r = v;
    for (int i = 0; i < ELEMENTS; i++) begin
      if (forest[lvl][r] < 0 || forest[lvl][r] >= ELEMENTS) break;
      r = idx_t'(forest[lvl][r]);
    end
    cur = v;
    for (int i = 0; i < ELEMENTS && cur != r; i++) begin
      if (forest[lvl][cur] < 0 || forest[lvl][cur] >= ELEMENTS) break;
      nxt = idx_t'(forest[lvl][cur]);
      forest[lvl][cur] = {2'b00, r};
      cur = nxt;
    end
    return r;
  endfunction

  function automatic bit unite(int lvl, idx_t a, idx_t b, output idx_t keep, output idx_t gone);
    idx_t ra, rb, t;
    ra = find_root(lvl, a);
    rb = find_root(lvl, b);
    keep = '0;
    gone = '0;
    if (ra == rb) return 1'b0;
    if (forest[lvl][ra] < forest[lvl][rb]) begin
      t = ra; ra = rb; rb = t;
    end
    forest[lvl][ra] = forest[lvl][ra] + forest[lvl][rb];
    forest[lvl][rb] = {2'b00, ra};
    keep = ra;
    gone = rb;
    return 1'b1;
  endfunction

  function automatic void push_block(int x, int y, int k);
    blk_t b;
    b.x = idx_t'(x);
    b.y = idx_t'(y);
    b.k = lvl_t'(k);
    if (split_q.size() < STK_DEPTH) split_q.push_back(b);
  endfunction

  // expected results of one accepted command, appended in order
  function automatic void predict_command(cmd_t c, idx_t x, idx_t y, logic [LEN_W-1:0] len);
    outcome_t o;
    blk_t b;
    idx_t keep, gone;
    int n, k, off, h;
    bit hit;
    n = 0;
    o = '0;
    if (c == CMD_MERGE) begin
      if (int'(x) + int'(len) > ELEMENTS || int'(y) + int'(len) > ELEMENTS) begin
        o.f.range_error = 1'b1;
        outcome_q.push_back(o);
        n = 1;
      end else if (len > 0) begin
        k = 0;
        while ((2 << k) <= int'(len) - 1) k++;
        off = int'(len) - (1 << k);
        split_q.delete();
        push_block(x + off, y + off, k);
        push_block(x, y, k);
        while (split_q.size() > 0) begin
          b = split_q.pop_back();
          if (b.k == 0) begin
            hit = unite(0, b.x, b.y, keep, gone);
            if (hit && n < 64) begin
              o = '0;
              o.f.new_root = keep;
              o.f.absorbed_root = gone;
              o.f.pair_valid = 1'b1;
              outcome_q.push_back(o);
              n++;
            end
            continue;
          end
          if (b.k < LEVELS) begin
            hit = unite(b.k, b.x, b.y, keep, gone);
            if (!hit) continue;
          end
          h = 1 << (b.k - 1);
          push_block(b.x + h, b.y + h, b.k - 1);
          push_block(b.x, b.y, b.k - 1);
        end
      end
      if (n == 0) begin
        o = '0;
        outcome_q.push_back(o);
      end
    end else if (c == CMD_SAME) begin
      if (x >= ELEMENTS || y >= ELEMENTS) o.f.range_error = 1'b1;
      else o.f.same_set = (find_root(0, x) == find_root(0, y));
      outcome_q.push_back(o);
    end else if (c == CMD_ROOT) begin
      if (x >= ELEMENTS) o.f.range_error = 1'b1;
      else o.f.root_index = find_root(0, x);
      outcome_q.push_back(o);
    end else begin
      outcome_q.push_back(o);
    end
    outcome_q[$].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    outcome_t w;
    if (rst) begin
      for (int l = 0; l < LEVELS; l++)
        for (int e = 0; e < ELEMENTS; e++) forest[l][e] = '1;
      split_q.delete();
      outcome_q.delete();
    end else begin
      if (req.valid && req.ready)
        predict_command(cmd_t'(req.cmd), req.first_index, req.second_index, req.run_length);
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t unexpected result expected none actual root %0d/%0d", $time,
                   rsp.new_root, rsp.absorbed_root);
          errors++;
        end else begin
          w = outcome_q.pop_front();
          check_field("new_root", w.f.new_root, rsp.new_root);
          check_field("absorbed_root", w.f.absorbed_root, rsp.absorbed_root);
          check_field("pair_valid", w.f.pair_valid, rsp.pair_valid);
          check_field("same_set", w.f.same_set, rsp.same_set);
          check_field("root_index", w.f.root_index, rsp.root_index);
          check_field("range_error", w.f.range_error, rsp.range_error);
          check_field("last", w.last, rsp.last);
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

FILE: tb/range_parallel_union_find_top_test.sv
`timescale 1ns / 1ps
// testbench top: command stimulus, result back-pressure and verdict for the union-find engine
module range_parallel_union_find_top_test;
  import rpuf_pkg::*;

  localparam int ELEMENTS   = 64;
  localparam int LEVELS     = 7;
  localparam int CYCLE_CAP  = 20_000_000;  // far above the slowest legal run
  localparam int DRAIN_WAIT = 300;         // catches stray results after the last expected one
  localparam int RAND_ITEMS = 280;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycles = 0;
  bit   calm;        // stretch with no idling on either side

  rpuf_req_if req ();
  rpuf_rsp_if rsp ();

  range_parallel_union_find_top #(.ELEMENTS(ELEMENTS), .LEVELS(LEVELS)) dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  rpuf_checker #(.ELEMENTS(ELEMENTS), .LEVELS(LEVELS)) u_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("range_parallel_union_find_top: mismatch");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  // result back-pressure: ready held for a random number of cycles at a time
  int hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end else if (calm) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 3) != 0);
      hold <= pick_gap();
    end
  end

  // one command transfer; valid stays high across back-to-back commands
  task automatic send_command(cmd_t c, int x, int y, int len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.cmd          <= c;
    req.first_index  <= idx_t'(x);
    req.second_index <= idx_t'(y);
    req.run_length   <= LEN_W'(len);
    do @(posedge clk); while (!req.ready);
  endtask

  // random command: mostly in-range merges of short runs, also noise merges, queries and no-ops
  task automatic send_random();
    int pick, len, x, y;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) < 7) len = $urandom_range(1, 8);
      else len = $urandom_range(0, 64);
      x = $urandom_range(0, ELEMENTS - len);
      y = $urandom_range(0, ELEMENTS - len);
      send_command(CMD_MERGE, x, y, len);
    end else if (pick < 62) begin
      // noise: any run length, often past the end
      send_command(CMD_MERGE, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 127));
    end else if (pick < 78) begin
      send_command(CMD_SAME, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 127));
    end else if (pick < 95) begin
      send_command(CMD_ROOT, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 127));
    end else begin
      send_command(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 127));
    end
  endtask

  initial begin
    calm = 1'b0;
    req.valid        <= 1'b0;
    req.cmd          <= CMD_MERGE;
    req.first_index  <= '0;
    req.second_index <= '0;
    req.run_length   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: corner runs, every command, each special case
    send_command(CMD_ROOT, 63, 0, 0);
    send_command(CMD_SAME, 0, 63, 0);
    send_command(CMD_MERGE, 0, 0, 64);     // element with itself: no union
    send_command(CMD_MERGE, 5, 9, 0);      // empty run
    send_command(CMD_MERGE, 60, 0, 10);    // first run past the end
    send_command(CMD_MERGE, 0, 63, 2);     // second run past the end
    send_command(CMD_MERGE, 1, 2, 127);    // widest run length field
    send_command(CMD_NONE, 63, 63, 127);   // unknown command
    send_command(CMD_MERGE, 0, 1, 1);      // single pair
    send_command(CMD_MERGE, 2, 3, 1);
    send_command(CMD_MERGE, 1, 3, 1);      // tie in size
    send_command(CMD_MERGE, 8, 0, 1);      // larger set onto a singleton
    send_command(CMD_MERGE, 16, 32, 3);    // overlapping blocks
    send_command(CMD_MERGE, 16, 32, 3);    // repeat gives no union
    send_command(CMD_MERGE, 20, 40, 5);
    send_command(CMD_MERGE, 0, 32, 32);    // largest in-range shifted run
    send_command(CMD_SAME, 0, 32, 0);
    send_command(CMD_SAME, 0, 63, 0);
    send_command(CMD_ROOT, 3, 0, 0);
    send_command(CMD_MERGE, 0, 1, 63);     // chains everything together
    send_command(CMD_ROOT, 63, 0, 0);
    send_command(CMD_MERGE, 63, 0, 1);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = ((i / 40) % 4 == 2);
      send_random();
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    // let the last transfer reach the predictor before counting what is left
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("range_parallel_union_find_top: match");
    end else begin
      $display("range_parallel_union_find_top: mismatch");
    end
    $finish;
  end

endmodule
